/* src/building_thermal_step_ideal_hvac_macros.svh */
// Assertion macros shared by the thermal step design.
`ifndef BUILDING_THERMAL_STEP_IDEAL_HVAC_MACROS_SVH
`define BUILDING_THERMAL_STEP_IDEAL_HVAC_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BTHS_ASSERT_IMPL(name, clock, rstn, cond, expr, msg) \
	name: assert property (@(posedge clock) disable iff (!rstn) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BTHS_ASSERT_NEXT(name, clock, rstn, cond, expr, msg) \
	name: assert property (@(posedge clock) disable iff (!rstn) (cond) |=> (expr)) \
		else $error(msg);

`endif

/* src/bths_pkg.sv */
// Shared constants and side-band types for the thermal step pipeline.
`timescale 1ns / 1ps
package bths_pkg;

	typedef enum logic [1:0] {
		CFG_HEAT_SP = 2'd0,
		CFG_COOL_SP = 2'd1,
		CFG_AMBIENT = 2'd2,
		CFG_STEP    = 2'd3
	} cfg_idx_t;

	localparam logic signed [15:0] HEAT_SP_RST = 16'sd5376;
	localparam logic signed [15:0] COOL_SP_RST = 16'sd6656;
	localparam logic signed [15:0] AMBIENT_RST = 16'sd7680;
	localparam logic [15:0]        STEP_RST    = 16'd2000;

	// Carried alongside the free-running temperature division.
	typedef struct packed {
		logic signed [15:0] temp;
		logic               fneg;
		logic signed [48:0] flow;
		logic [39:0]        cap;
		logic signed [31:0] hlim;
		logic signed [31:0] clim;
	} side1_t;

	// Carried alongside the raw power division.
	typedef struct packed {
		logic signed [15:0] temp;
		logic signed [48:0] flow;
		logic [39:0]        cap;
		logic               dneg;
		logic               inband;
		logic               ovf;
		logic signed [31:0] lim;
	} side2_t;

	// Carried alongside the next temperature division.
	typedef struct packed {
		logic signed [15:0] temp;
		logic               sneg;
		logic               ovf;
		logic signed [31:0] power;
	} side3_t;

endpackage

/* src/bths_in_if.sv */
// Zone item channel.
`timescale 1ns / 1ps
interface bths_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] zone_temp;
	logic [31:0]        transmission;
	logic [39:0]        capacity;
	logic signed [31:0] heat_limit;
	logic signed [31:0] cool_limit;

	modport source(output valid, zone_temp, transmission, capacity, heat_limit, cool_limit,
		input ready);
	modport sink(input valid, zone_temp, transmission, capacity, heat_limit, cool_limit,
		output ready);
endinterface

/* src/bths_out_if.sv */
// Result item channel.
`timescale 1ns / 1ps
interface bths_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive_power;
	logic signed [15:0] next_temp;

	modport source(output valid, drive_power, next_temp, input ready);
	modport sink(input valid, drive_power, next_temp, output ready);
endinterface

/* src/bths_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module bths_div #(
	parameter int NW = 56,
	parameter int DW = 40,
	parameter int QW = 56,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	// The caller guarantees num < den * 2**QW, so the upper part is below den.
	logic [NW-1:0] num_hi;
	logic [QW-1:0] valid_s;
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];
	logic [DW-1:0] rem_src  [QW];
	logic [QW-1:0] low_src  [QW];
	logic [DW-1:0] den_src  [QW];
	logic [SW-1:0] side_src [QW];
	logic [DW:0]   trial [QW];
	logic [DW:0]   diff  [QW];

	assign num_hi = num >> QW;

	always_comb begin
		rem_src[0]  = num_hi[DW-1:0];
		low_src[0]  = num[QW-1:0];
		den_src[0]  = den;
		side_src[0] = side_in;
		for (int k = 1; k < QW; k++) begin
			rem_src[k]  = rem_s[k-1];
			low_src[k]  = low_s[k-1];
			den_src[k]  = den_s[k-1];
			side_src[k] = side_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial[k] = {rem_src[k], low_src[k][QW-1]};
			diff[k]  = trial[k] - {1'b0, den_src[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[QW-2:0], in_valid};
		end
	end

	// A clear borrow bit means the trial remainder reached the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k]  <= diff[k][DW] ? trial[k][DW-1:0] : diff[k][DW-1:0];
				low_s[k]  <= {low_src[k][QW-2:0], ~diff[k][DW]};
				den_s[k]  <= den_src[k];
				side_s[k] <= side_src[k];
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign quo       = low_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

/* src/building_thermal_step_ideal_hvac.sv */
// Top level of the single-zone thermal step with ideal heating and cooling.
//
//   channel   kind        payload
//   zone      sink        zone_temp, transmission, capacity, heat_limit, cool_limit
//   result    source      drive_power, next_temp
//   cfg_*     write port  heat/cool set point, ambient temperature, step seconds
//
// One item enters per clock while the result channel is not stalled.
// Most of the pipeline is three restoring dividers of 56, 32 and 17 one-bit stages.
// Reset clears every valid bit and loads the default registers; no clearing pass.
// When the output item is not taken the whole pipeline holds, so nothing is lost.
`timescale 1ns / 1ps
`include "building_thermal_step_ideal_hvac_macros.svh"
module building_thermal_step_ideal_hvac (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	bths_in_if.sink     zone,
	bths_out_if.source  result
);

	logic signed [15:0] heat_sp_q, cool_sp_q, amb_q;
	logic [15:0]        dt_q;
	logic               en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;

	logic signed [15:0] t_s1, t_s2;
	logic signed [16:0] dtmp_s1;
	logic [31:0]        h_s1;
	logic [39:0]        c_s1, c_s2;
	logic signed [31:0] hl_s1, cl_s1, hl_s2, cl_s2;
	logic [16:0]        dabs;
	logic [47:0]        fmag_s2;
	logic               fneg_s2;

	logic [63:0]          x3;
	logic [55:0]          n1_s3;
	bths_pkg::side1_t     side1_s3, side1_s4, d1_side;
	logic                 d1_valid;
	logic [55:0]          q1;
	logic signed [57:0]   q1s, t0_c, t0_s4, hs58, cs58;

	logic                 below5, above5;
	logic signed [58:0]   d_s5;
	logic signed [31:0]   lim_s5, lim_s6, lim_s7, lim_s8;
	logic                 inband_s5, inband_s6, inband_s7, inband_s8;
	logic signed [15:0]   t_s5, t_s6, t_s7, t_s8;
	logic signed [48:0]   flow_s5, flow_s6, flow_s7, flow_s8;
	logic [39:0]          c_s5, c_s6, c_s7, c_s8;

	logic [58:0]          dabs59;
	logic [56:0]          dmag_s6;
	logic                 dneg_s6, dneg_s7, dneg_s8;
	logic [48:0]          pp_ll_s7, pp_lh_s7;
	logic [47:0]          pp_hl_s7, pp_hh_s7;
	logic [96:0]          n2;
	logic [88:0]          n2s_s8;
	logic                 ovf2;
	logic [47:0]          num2_s9;
	bths_pkg::side2_t     side2_s9, d2_side;
	logic                 d2_valid;
	logic [31:0]          q2;

	logic [31:0]          lmag10;
	logic                 use_raw10;
	logic signed [32:0]   raw10;
	logic signed [31:0]   pwr10;
	logic signed [31:0]   power_s10, power_s11, power_s12, power_s13;
	logic signed [15:0]   t_s10, t_s11, t_s12, t_s13;
	logic signed [48:0]   flow_s10;
	logic [39:0]          c_s10, c_s11, c_s12, c_s13, c_s14;
	logic signed [47:0]   pshift;
	logic signed [49:0]   ssum_s11;
	logic [49:0]          sabs;
	logic [48:0]          smag_s12;
	logic                 sneg_s12, sneg_s13;
	logic [64:0]          y13;
	logic [56:0]          n3_s13;
	logic                 ovf3;
	logic [56:0]          num3_s14;
	bths_pkg::side3_t     side3_s14, d3_side;
	logic                 d3_valid;
	logic [16:0]          q3;

	logic [17:0]          qx;
	logic signed [19:0]   t1;
	logic signed [15:0]   t1_sat;
	logic signed [31:0]   power_s15;
	logic signed [15:0]   temp_s15;

	// Configuration; a zero step length is stored as one second.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_sp_q <= bths_pkg::HEAT_SP_RST;
			cool_sp_q <= bths_pkg::COOL_SP_RST;
			amb_q     <= bths_pkg::AMBIENT_RST;
			dt_q      <= bths_pkg::STEP_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				bths_pkg::CFG_HEAT_SP: heat_sp_q <= cfg_wdata;
				bths_pkg::CFG_COOL_SP: cool_sp_q <= cfg_wdata;
				bths_pkg::CFG_AMBIENT: amb_q     <= cfg_wdata;
				bths_pkg::CFG_STEP:    dt_q      <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en         = !v_s15 || result.ready;
	assign zone.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			{v_s10, v_s11, v_s12, v_s13, v_s14, v_s15} <= '0;
		end else if (en) begin
			v_s1  <= zone.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= d1_valid;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= d2_valid;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= d3_valid;
		end
	end

	// Front: heat flow magnitude and the numerator of the first division.
	assign dabs = dtmp_s1[16] ? 17'(-dtmp_s1) : 17'(dtmp_s1);
	assign x3   = 64'(fmag_s2) * 64'(dt_q);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= zone.zone_temp;
			dtmp_s1 <= 17'(amb_q) - 17'(zone.zone_temp);
			h_s1    <= zone.transmission;
			c_s1    <= (zone.capacity == 40'd0) ? 40'd1 : zone.capacity;
			hl_s1   <= zone.heat_limit;
			cl_s1   <= zone.cool_limit;

			t_s2    <= t_s1;
			fmag_s2 <= 48'(h_s1) * 48'(dabs[15:0]);
			fneg_s2 <= dtmp_s1[16];
			c_s2    <= c_s1;
			hl_s2   <= hl_s1;
			cl_s2   <= cl_s1;

			n1_s3         <= x3[63:8];
			side1_s3.temp <= t_s2;
			side1_s3.fneg <= fneg_s2;
			side1_s3.flow <= fneg_s2 ? -signed'({1'b0, fmag_s2}) : signed'({1'b0, fmag_s2});
			side1_s3.cap  <= c_s2;
			side1_s3.hlim <= hl_s2;
			side1_s3.clim <= cl_s2;
		end
	end

	bths_div #(
		.NW(56), .DW(40), .QW(56), .SW($bits(bths_pkg::side1_t))
	) u_div_free (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(n1_s3), .den(side1_s3.cap), .side_in(side1_s3),
		.out_valid(d1_valid), .quo(q1), .side_out(d1_side)
	);

	// Free-running temperature, band test and the raw power numerator.
	assign q1s    = signed'({2'b0, q1});
	assign t0_c   = 58'(d1_side.temp) + (d1_side.fneg ? -q1s : q1s);
	assign hs58   = 58'(heat_sp_q);
	assign cs58   = 58'(cool_sp_q);
	assign below5 = t0_s4 < hs58;
	assign above5 = t0_s4 > cs58;
	assign dabs59 = d_s5[58] ? 59'(-d_s5) : 59'(d_s5);
	assign n2     = 97'(pp_ll_s7) + (97'(pp_lh_s7) << 20) + (97'(pp_hl_s7) << 29)
		+ (97'(pp_hh_s7) << 49);
	assign ovf2   = n2s_s8[88:32] >= 57'(dt_q);

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s4    <= t0_c;
			side1_s4 <= d1_side;

			inband_s5 <= !below5 && !above5;
			d_s5      <= below5 ? 59'(hs58) - 59'(t0_s4) : 59'(cs58) - 59'(t0_s4);
			lim_s5    <= below5 ? side1_s4.hlim : side1_s4.clim;
			t_s5      <= side1_s4.temp;
			flow_s5   <= side1_s4.flow;
			c_s5      <= side1_s4.cap;

			dmag_s6   <= dabs59[56:0];
			dneg_s6   <= d_s5[58];
			inband_s6 <= inband_s5;
			lim_s6    <= lim_s5;
			t_s6      <= t_s5;
			flow_s6   <= flow_s5;
			c_s6      <= c_s5;

			// The 57 by 40 bit product is split into four narrow ones.
			pp_ll_s7  <= 49'(dmag_s6[28:0]) * 49'(c_s6[19:0]);
			pp_lh_s7  <= 49'(dmag_s6[28:0]) * 49'(c_s6[39:20]);
			pp_hl_s7  <= 48'(dmag_s6[56:29]) * 48'(c_s6[19:0]);
			pp_hh_s7  <= 48'(dmag_s6[56:29]) * 48'(c_s6[39:20]);
			dneg_s7   <= dneg_s6;
			inband_s7 <= inband_s6;
			lim_s7    <= lim_s6;
			t_s7      <= t_s6;
			flow_s7   <= flow_s6;
			c_s7      <= c_s6;

			n2s_s8    <= n2[96:8];
			dneg_s8   <= dneg_s7;
			inband_s8 <= inband_s7;
			lim_s8    <= lim_s7;
			t_s8      <= t_s7;
			flow_s8   <= flow_s7;
			c_s8      <= c_s7;

			// A quotient of 2**32 or more always exceeds the limit magnitude.
			num2_s9         <= ovf2 ? 48'd0 : n2s_s8[47:0];
			side2_s9.temp   <= t_s8;
			side2_s9.flow   <= flow_s8;
			side2_s9.cap    <= c_s8;
			side2_s9.dneg   <= dneg_s8;
			side2_s9.inband <= inband_s8;
			side2_s9.ovf    <= ovf2;
			side2_s9.lim    <= lim_s8;
		end
	end

	bths_div #(
		.NW(48), .DW(16), .QW(32), .SW($bits(bths_pkg::side2_t))
	) u_div_raw (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s9),
		.num(num2_s9), .den(dt_q), .side_in(side2_s9),
		.out_valid(d2_valid), .quo(q2), .side_out(d2_side)
	);

	// Power selection; only a raw power of exactly 2**31 needs clamping.
	always_comb begin
		lmag10    = d2_side.lim[31] ? 32'(-d2_side.lim) : 32'(d2_side.lim);
		use_raw10 = !d2_side.ovf && (q2 <= lmag10);
		raw10     = d2_side.dneg ? -signed'({1'b0, q2}) : signed'({1'b0, q2});
		if (d2_side.inband) begin
			pwr10 = '0;
		end else if (!use_raw10) begin
			pwr10 = d2_side.lim;
		end else if (!raw10[32] && raw10[31]) begin
			pwr10 = 32'sh7fffffff;
		end else begin
			pwr10 = raw10[31:0];
		end
	end

	assign pshift = {power_s10, 16'b0};
	assign sabs   = ssum_s11[49] ? 50'(-ssum_s11) : 50'(ssum_s11);
	assign y13    = 65'(smag_s12) * 65'(dt_q);
	assign ovf3   = n3_s13[56:17] >= c_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			power_s10 <= pwr10;
			t_s10     <= d2_side.temp;
			flow_s10  <= d2_side.flow;
			c_s10     <= d2_side.cap;

			ssum_s11  <= 50'(flow_s10) + 50'(pshift);
			power_s11 <= power_s10;
			t_s11     <= t_s10;
			c_s11     <= c_s10;

			smag_s12  <= sabs[48:0];
			sneg_s12  <= ssum_s11[49];
			power_s12 <= power_s11;
			t_s12     <= t_s11;
			c_s12     <= c_s11;

			n3_s13    <= y13[64:8];
			sneg_s13  <= sneg_s12;
			power_s13 <= power_s12;
			t_s13     <= t_s12;
			c_s13     <= c_s12;

			// Beyond 2**17 the next temperature saturates whatever the exact quotient.
			num3_s14        <= ovf3 ? 57'd0 : n3_s13;
			side3_s14.temp  <= t_s13;
			side3_s14.sneg  <= sneg_s13;
			side3_s14.ovf   <= ovf3;
			side3_s14.power <= power_s13;
			c_s14           <= c_s13;
		end
	end

	bths_div #(
		.NW(57), .DW(40), .QW(17), .SW($bits(bths_pkg::side3_t))
	) u_div_next (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s14),
		.num(num3_s14), .den(c_s14), .side_in(side3_s14),
		.out_valid(d3_valid), .quo(q3), .side_out(d3_side)
	);

	always_comb begin
		qx = d3_side.ovf ? 18'h20000 : {1'b0, q3};
		t1 = 20'(d3_side.temp) + (d3_side.sneg ? -signed'({2'b0, qx}) : signed'({2'b0, qx}));
		if (t1 > 20'sd32767) begin
			t1_sat = 16'sh7fff;
		end else if (t1 < -20'sd32768) begin
			t1_sat = 16'sh8000;
		end else begin
			t1_sat = t1[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			power_s15 <= d3_side.power;
			temp_s15  <= t1_sat;
		end
	end

	assign result.valid       = v_s15;
	assign result.drive_power = power_s15;
	assign result.next_temp   = temp_s15;

	`BTHS_ASSERT_IMPL(a_stall_blocks_input, clk, arst_n, result.valid && !result.ready, !zone.ready, "input item taken while the output item is stalled")
	`BTHS_ASSERT_NEXT(a_accept_enters, clk, arst_n, zone.valid && zone.ready, v_s1, "accepted item missing from the first stage")
	`BTHS_ASSERT_IMPL(a_cool_flow_lowers, clk, arst_n, v_s4 && side1_s4.fneg, t0_s4 <= 58'(side1_s4.temp), "outward heat flow raised the free-running temperature")
	`BTHS_ASSERT_IMPL(a_sat_on_overflow, clk, arst_n, d3_valid && d3_side.ovf, t1_sat == 16'sh7fff || t1_sat == 16'sh8000, "large temperature change did not saturate")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the single-zone thermal step with ideal heating and cooling.
`timescale 1ns / 1ps
module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 150;
	localparam int ITEMS_PER_PHASE = 320;
	localparam int NUM_PHASES = 6;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic signed [15:0] zone_temp;
		logic [31:0]        transmission;
		logic [39:0]        capacity;
		logic signed [31:0] heat_limit;
		logic signed [31:0] cool_limit;
	} zone_item_t;

	typedef struct {
		logic signed [31:0] power;
		logic signed [15:0] temp;
	} step_result_t;

	typedef struct {
		zone_item_t   zone;
		bit           typed;
		step_result_t want;
	} directed_row_t;

	typedef struct {
		logic signed [15:0] heat_sp;
		logic signed [15:0] cool_sp;
		logic signed [15:0] ambient;
		logic [15:0]        step_len;
	} setting_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	bths_in_if  zone_ch();
	bths_out_if res_ch();

	building_thermal_step_ideal_hvac u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.zone(zone_ch),
		.result(res_ch)
	);

	// Shadow copy of the block's registers.
	logic signed [15:0] heat_sp = bths_pkg::HEAT_SP_RST;
	logic signed [15:0] cool_sp = bths_pkg::COOL_SP_RST;
	logic signed [15:0] ambient = bths_pkg::AMBIENT_RST;
	logic [15:0]        step_len = bths_pkg::STEP_RST;

	step_result_t pending_steps[$];
	int errors = 0;
	int cycles = 0;
	int zones_in = 0;
	int steps_out = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_go = 0;
	bit hold_seen = 0;
	int hold_left = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// trunc(num * mul / dvs) on magnitudes, quotient capped at 2^62.
	function automatic longint scale_trunc(longint num, longint unsigned mul,
		longint unsigned dvs);
		logic [127:0] prod;
		logic [127:0] quot;
		longint unsigned mag;
		mag = (num < 0) ? 64'(-num) : 64'(num);
		prod = 128'(mag) * 128'(mul);
		quot = prod / 128'(dvs);
		if (quot > (128'(1) << 62))
			quot = 128'(1) << 62;
		return (num < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
	endfunction

	function automatic step_result_t predict_step(zone_item_t z);
		step_result_t r;
		longint t, h, ta, hs, cs, flow, t0, p, t1, sp, lim, raw;
		longint unsigned c, dt, rmag, lmag;
		t = longint'(z.zone_temp);
		h = longint'(z.transmission);
		c = 64'(z.capacity);
		hs = longint'(heat_sp);
		cs = longint'(cool_sp);
		ta = longint'(ambient);
		dt = 64'(step_len);
		if (c == 0) c = 1;
		if (dt == 0) dt = 1;
		flow = h * (ta - t);
		t0 = t + scale_trunc(flow, dt, c * 256);
		if (t0 >= hs && t0 <= cs) begin
			p = 0;
		end else begin
			if (t0 < hs) begin
				sp = hs;
				lim = longint'(z.heat_limit);
			end else begin
				sp = cs;
				lim = longint'(z.cool_limit);
			end
			raw = scale_trunc(sp - t0, c, dt * 256);
			rmag = (raw < 0) ? 64'(-raw) : 64'(raw);
			lmag = (lim < 0) ? 64'(-lim) : 64'(lim);
			p = (rmag <= lmag) ? raw : lim;
			if (p > 64'sd2147483647) p = 64'sd2147483647;
			if (p < -64'sd2147483648) p = -64'sd2147483648;
		end
		t1 = t + scale_trunc(flow + p * 65536, dt, c * 256);
		if (t1 > 32767) t1 = 32767;
		if (t1 < -32768) t1 = -32768;
		r.power = 32'(p);
		r.temp = 16'(t1);
		return r;
	endfunction

	task automatic report_err(string what, longint want, longint got);
		$display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		errors++;
	endtask

	// Acceptance on both channels, checking and the cycle limit.
	always @(posedge clk) begin
		step_result_t w;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end else begin
			if (arst_n && zone_ch.valid && zone_ch.ready) begin
				pending_steps.push_back(predict_step('{zone_ch.zone_temp,
					zone_ch.transmission, zone_ch.capacity, zone_ch.heat_limit,
					zone_ch.cool_limit}));
				zones_in++;
			end
			if (arst_n && res_ch.valid && res_ch.ready) begin
				steps_out++;
				if (pending_steps.size() == 0) begin
					report_err("unexpected result item, power", 0, res_ch.drive_power);
				end else begin
					w = pending_steps.pop_front();
					if (res_ch.drive_power !== w.power)
						report_err("drive_power", w.power, res_ch.drive_power);
					if (res_ch.next_temp !== w.temp)
						report_err("next_temp", w.temp, res_ch.next_temp);
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here when asked for.
	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_zone(zone_item_t z);
		while ($urandom_range(99) < send_idle_pct) begin
			zone_ch.valid <= 1'b0;
			@(negedge clk);
		end
		zone_ch.valid <= 1'b1;
		zone_ch.zone_temp <= z.zone_temp;
		zone_ch.transmission <= z.transmission;
		zone_ch.capacity <= z.capacity;
		zone_ch.heat_limit <= z.heat_limit;
		zone_ch.cool_limit <= z.cool_limit;
		@(posedge clk);
		while (!zone_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(bths_pkg::cfg_idx_t idx, logic [15:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			bths_pkg::CFG_HEAT_SP: heat_sp = data;
			bths_pkg::CFG_COOL_SP: cool_sp = data;
			bths_pkg::CFG_AMBIENT: ambient = data;
			bths_pkg::CFG_STEP:    step_len = data;
			default: ;
		endcase
	endtask

	task automatic apply_setting(setting_t s);
		zone_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_steps.size() != 0)
			@(negedge clk);
		write_reg(bths_pkg::CFG_HEAT_SP, s.heat_sp);
		write_reg(bths_pkg::CFG_COOL_SP, s.cool_sp);
		write_reg(bths_pkg::CFG_AMBIENT, s.ambient);
		write_reg(bths_pkg::CFG_STEP, s.step_len);
	endtask

	function automatic zone_item_t random_zone();
		zone_item_t z;
		int mag;
		if ($urandom_range(3) == 0)
			z.zone_temp = 16'($urandom);
		else
			z.zone_temp = 16'(int'(heat_sp) - 2000 + int'($urandom_range(5000)));
		z.transmission = $urandom >> $urandom_range(31);
		if ($urandom_range(49) == 0)
			z.capacity = '0;
		else
			z.capacity = 40'({$urandom, $urandom} >> (24 + $urandom_range(39)));
		if ($urandom_range(7) == 0) begin
			z.heat_limit = $urandom;
			z.cool_limit = $urandom;
		end else begin
			mag = int'($urandom >> (1 + $urandom_range(30)));
			z.heat_limit = mag;
			mag = int'($urandom >> (1 + $urandom_range(30)));
			z.cool_limit = -mag;
		end
		return z;
	endfunction

	// Directed rows run under the reset settings: heat 21 C, cool 26 C, outside 30 C.
	directed_row_t directed[] = '{
		'{'{16'sd6000, 32'd0, 40'd1000, 32'sd1000, -32'sd1000}, 1'b1, '{32'sd0, 16'sd6000}},
		'{'{16'sh7fff, 32'd0, 40'd1, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 16'sh7fff}},
		'{'{16'sh8000, 32'd0, 40'd1, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 16'sh8000}},
		'{'{16'sh8000, 32'hffffffff, 40'd0, 32'sh7fffffff, 32'sh80000000}, 1'b0, '{0, 0}},
		'{'{16'sh7fff, 32'hffffffff, 40'hff_ffff_ffff, 32'sh7fffffff, 32'sh80000000},
			1'b0, '{0, 0}},
		'{'{16'sd0, 32'd0, 40'd1000, -32'sd5, 32'sd5}, 1'b0, '{0, 0}},
		'{'{16'sd9000, 32'd0, 40'd1000, 32'sd5, 32'sd7}, 1'b0, '{0, 0}},
		'{'{16'sh8000, 32'd0, 40'd28825283866, 32'sh80000000, 32'sd0}, 1'b0, '{0, 0}},
		'{'{16'sd5000, 32'd2560, 40'd500000, 32'sd100000, -32'sd100000}, 1'b0, '{0, 0}},
		'{'{16'sd7000, 32'd256, 40'd300000, 32'sd10, -32'sd10}, 1'b0, '{0, 0}},
		'{'{16'sd5376, 32'h80000000, 40'h80_0000_0000, 32'sh55555555, 32'shaaaaaaaa},
			1'b0, '{0, 0}},
		'{'{16'sd6656, 32'h55555555, 40'h55_5555_5555, 32'shaaaaaaaa, 32'sh55555555},
			1'b0, '{0, 0}}
	};

	setting_t settings[NUM_PHASES] = '{
		'{bths_pkg::HEAT_SP_RST, bths_pkg::COOL_SP_RST, bths_pkg::AMBIENT_RST,
			bths_pkg::STEP_RST},
		'{16'sd5376, 16'sd6656, -16'sd2560, 16'd900},
		'{16'sd7000, 16'sd5000, 16'sd7680, 16'd1},
		'{16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff},
		'{16'sh7fff, 16'sh8000, 16'sh8000, 16'd0},
		'{16'sd4000, 16'sd5000, 16'sd1000, 16'd3600}
	};

	initial begin
		step_result_t last_pred;
		cfg_wen = 1'b0;
		cfg_idx = bths_pkg::CFG_HEAT_SP;
		cfg_wdata = '0;
		zone_ch.valid = 1'b0;
		zone_ch.zone_temp = '0;
		zone_ch.transmission = '0;
		zone_ch.capacity = '0;
		zone_ch.heat_limit = '0;
		zone_ch.cool_limit = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0)
				apply_setting(settings[ph]);
			send_idle_pct = (ph % 3 == 0) ? 26 : (ph % 3 == 1) ? 68 : 0;
			recv_idle_pct = (ph % 3 == 0) ? 68 : (ph % 3 == 1) ? 26 : 0;
			if (ph == 0) begin
				foreach (directed[i]) begin
					send_zone(directed[i].zone);
					// The newest prediction belongs to the item just accepted.
					if (directed[i].typed) begin
						last_pred = pending_steps[$];
						if (last_pred.power !== directed[i].want.power)
							report_err("typed row drive_power", directed[i].want.power,
								last_pred.power);
						if (last_pred.temp !== directed[i].want.temp)
							report_err("typed row next_temp", directed[i].want.temp,
								last_pred.temp);
					end
				end
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 2 && n == 50)
					hold_go = !hold_go;
				send_zone(random_zone());
			end
		end
		zone_ch.valid <= 1'b0;
		while (pending_steps.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d zone items through %0d register settings, %0d results checked.",
			zones_in, NUM_PHASES, steps_out);
		$display("Covered crossed set points, extreme temperatures and 0 s and 65535 s steps.");
		if (errors == 0 && pending_steps.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/bths_pkg.sv
src/bths_in_if.sv
src/bths_out_if.sv
src/bths_div.sv
src/building_thermal_step_ideal_hvac.sv
dv/testbench.sv
